[rtl/indexed_min_heap_decrement_top_defines.svh]
// assertion macros for the indexed min-heap checker
`ifndef INDEXED_MIN_HEAP_DECREMENT_TOP_DEFINES_SVH
`define INDEXED_MIN_HEAP_DECREMENT_TOP_DEFINES_SVH

// same-cycle implication, reset disables
`define IMH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("heap checker: same-cycle property failed");

// next-cycle implication, reset disables
`define IMH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("heap checker: next-cycle property failed");

`endif

[rtl/imh_pkg.sv]
// package with types and constants of the indexed min-heap
package imh_pkg;

  localparam int KEY_BITS       = 10;
  localparam int KEY_SPACE      = 1024;
  localparam int IN_VALUE_BITS  = 16;
  localparam int COUNT_BITS     = 11;
  localparam int CAPACITY_DEF   = 1024;
  localparam int VALUE_BITS_DEF = 16;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DEC    = 2'd1,
    ACT_POP    = 2'd2,
    ACT_NOP    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_DONE    = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_e;

  typedef struct packed {
    action_e                    action;
    logic [KEY_BITS-1:0]        item_key;
    logic [IN_VALUE_BITS-1:0]   item_value;
  } in_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]        out_key;
    logic [IN_VALUE_BITS-1:0]   out_value;
    status_e                    status;
    logic [COUNT_BITS-1:0]      count_after;
  } out_item_t;

endpackage

[rtl/imh_ram.sv]
// generic single-write, single-read ram with registered read data
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/indexed_min_heap_decrement_top.sv]
// indexed binary min-heap with insert, decrement and pop-min
//
// Input channel in_valid_i / in_stall_o carries one in_item_t per transaction:
// insert a (key, value) pair, decrement the value of a held key (saturating
// at zero), or pop the minimum. Output channel out_valid_o / out_stall_i
// returns exactly one out_item_t per input transaction, in order.
// After reset the key position table is cleared one entry a cycle, over the
// whole key space, during which in_stall_o is high.
// One transaction at a time: in_stall_o is high from acceptance until the
// result is loaded into the output register. A finished result waits there
// while out_stall_i is high; a new input transaction is accepted meanwhile,
// but its own result is held until the register frees.
// A full insert, an empty pop or the unused action code go straight to the
// output register; a present insert or an absent key first look up the key
// position table. An insert then climbs the heap, a decrement reads its slot
// and climbs, and a pop reads the root and, unless it was the last entry,
// reads the last entry and descends. Each level needs one registered read of
// the single heap read port (up to two on the way down) before the shared
// value comparator decides.
module indexed_min_heap_decrement_top
  import imh_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VB = VALUE_BITS;
  localparam int HW = KEY_BITS + VB;
  localparam int PW = SW + 1;
  localparam int KA = $clog2(KEY_SPACE);

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_POSW  = 14'b00000000000100,
    S_DECW  = 14'b00000000001000,
    S_UP    = 14'b00000000010000,
    S_UPW   = 14'b00000000100000,
    S_ROOT  = 14'b00000001000000,
    S_LAST  = 14'b00000010000000,
    S_DN    = 14'b00000100000000,
    S_DN1   = 14'b00001000000000,
    S_DN2   = 14'b00010000000000,
    S_DNC   = 14'b00100000000000,
    S_FIN   = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_e;

  state_e              state_q, state_d;
  logic [KA-1:0]       clr_q, clr_d;
  action_e             act_q, act_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [VB-1:0]       val_q, val_d;
  logic [SW-1:0]       idx_q, idx_d;
  logic [SW-1:0]       cidx_q, cidx_d;
  logic [KEY_BITS-1:0] cur_key_q, cur_key_d;
  logic [VB-1:0]       cur_val_q, cur_val_d;
  logic [KEY_BITS-1:0] ch_key_q, ch_key_d;
  logic [VB-1:0]       ch_val_q, ch_val_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [KEY_BITS-1:0] rkey_q, rkey_d;
  logic [VB-1:0]       rval_q, rval_d;
  status_e             stat_q, stat_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  logic                heap_we;
  logic [SW-1:0]       heap_waddr, heap_raddr;
  logic [HW-1:0]       heap_wdata, heap_rdata;
  logic                pos_we;
  logic [KA-1:0]       pos_waddr, pos_raddr;
  logic [PW-1:0]       pos_wdata, pos_rdata;

  logic [KEY_BITS-1:0] h_key;
  logic [VB-1:0]       h_val;
  logic                pos_present;
  logic [SW-1:0]       pos_slot;
  logic [SW-1:0]       parent;
  logic [SW+1:0]       c1, c2, cnt_x;
  logic [VB-1:0]       cmp_a, cmp_b;
  logic                cmp_lt;
  logic                in_acc;

  imh_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_heap_ram (
    .clk_i     (clk_i),
    .wr_en_i   (heap_we),
    .wr_addr_i (heap_waddr),
    .wr_data_i (heap_wdata),
    .rd_addr_i (heap_raddr),
    .rd_data_o (heap_rdata)
  );

  imh_ram #(.WIDTH(PW), .DEPTH(KEY_SPACE)) u_pos_ram (
    .clk_i     (clk_i),
    .wr_en_i   (pos_we),
    .wr_addr_i (pos_waddr),
    .wr_data_i (pos_wdata),
    .rd_addr_i (pos_raddr),
    .rd_data_o (pos_rdata)
  );

  assign h_key       = heap_rdata[HW-1 -: KEY_BITS];
  assign h_val       = heap_rdata[VB-1:0];
  assign pos_present = pos_rdata[SW];
  assign pos_slot    = pos_rdata[SW-1:0];
  assign parent      = SW'((idx_q - SW'(1)) >> 1);
  assign c1          = {1'b0, idx_q, 1'b1};
  assign c2          = c1 + (SW+2)'(1);
  assign cnt_x       = (SW+2)'(cnt_q);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // shared value comparator
  always_comb begin
    unique case (state_q)
      S_UPW: begin
        cmp_a = cur_val_q;
        cmp_b = h_val;
      end
      S_DN2: begin
        cmp_a = h_val;
        cmp_b = ch_val_q;
      end
      default: begin
        cmp_a = ch_val_q;
        cmp_b = cur_val_q;
      end
    endcase
  end
  assign cmp_lt = cmp_a < cmp_b;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    act_d       = act_q;
    key_d       = key_q;
    val_d       = val_q;
    idx_d       = idx_q;
    cidx_d      = cidx_q;
    cur_key_d   = cur_key_q;
    cur_val_d   = cur_val_q;
    ch_key_d    = ch_key_q;
    ch_val_d    = ch_val_q;
    cnt_d       = cnt_q;
    rkey_d      = rkey_q;
    rval_d      = rval_q;
    stat_d      = stat_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    heap_we     = 1'b0;
    heap_waddr  = idx_q;
    heap_wdata  = {cur_key_q, cur_val_q};
    heap_raddr  = '0;
    pos_we      = 1'b0;
    pos_waddr   = KA'(cur_key_q);
    pos_wdata   = {1'b1, idx_q};
    pos_raddr   = KA'(in_item_i.item_key);

    unique case (state_q)
      S_CLEAR: begin
        pos_we    = 1'b1;
        pos_waddr = clr_q;
        pos_wdata = '0;
        clr_d     = clr_q + KA'(1);
        if (clr_q == KA'(KEY_SPACE - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          act_d  = in_item_i.action;
          key_d  = in_item_i.item_key;
          val_d  = VB'(in_item_i.item_value);
          rkey_d = '0;
          rval_d = '0;
          stat_d = ST_DONE;
          unique case (in_item_i.action)
            ACT_INSERT: begin
              if (cnt_q == CW'(CAPACITY)) begin
                stat_d  = ST_FULL;
                state_d = S_DONE;
              end else begin
                state_d = S_POSW;
              end
            end
            ACT_DEC: state_d = S_POSW;
            ACT_POP: begin
              if (cnt_q == '0) begin
                stat_d  = ST_EMPTY;
                state_d = S_DONE;
              end else begin
                state_d = S_ROOT;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_POSW: begin
        if (act_q == ACT_INSERT) begin
          if (pos_present) begin
            stat_d  = ST_PRESENT;
            state_d = S_DONE;
          end else begin
            cnt_d     = cnt_q + CW'(1);
            cur_key_d = key_q;
            cur_val_d = val_q;
            idx_d     = SW'(cnt_q);
            state_d   = S_UP;
          end
        end else begin
          if (!pos_present) begin
            stat_d  = ST_ABSENT;
            state_d = S_DONE;
          end else if ((SW+2)'(pos_slot) >= cnt_x) begin
            state_d = S_DONE;
          end else begin
            idx_d      = pos_slot;
            heap_raddr = pos_slot;
            state_d    = S_DECW;
          end
        end
      end
      S_DECW: begin
        cur_key_d = h_key;
        cur_val_d = (h_val == '0) ? '0 : h_val - VB'(1);
        state_d   = S_UP;
      end
      S_UP: begin
        if (idx_q == '0) begin
          state_d = S_FIN;
        end else begin
          heap_raddr = parent;
          state_d    = S_UPW;
        end
      end
      S_UPW: begin
        heap_raddr = parent;
        if (cmp_lt) begin
          heap_we    = 1'b1;
          heap_wdata = heap_rdata;
          pos_we     = 1'b1;
          pos_waddr  = KA'(h_key);
          idx_d      = parent;
          state_d    = S_UP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_ROOT: begin
        rkey_d    = h_key;
        rval_d    = h_val;
        pos_we    = 1'b1;
        pos_waddr = KA'(h_key);
        pos_wdata = '0;
        cnt_d     = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = S_DONE;
        end else begin
          heap_raddr = SW'(cnt_q - CW'(1));
          state_d    = S_LAST;
        end
      end
      S_LAST: begin
        cur_key_d = h_key;
        cur_val_d = h_val;
        idx_d     = '0;
        state_d   = S_DN;
      end
      S_DN: begin
        if (c1 >= cnt_x) begin
          state_d = S_FIN;
        end else begin
          heap_raddr = SW'(c1);
          state_d    = S_DN1;
        end
      end
      S_DN1: begin
        ch_key_d = h_key;
        ch_val_d = h_val;
        cidx_d   = SW'(c1);
        if (c2 < cnt_x) begin
          heap_raddr = SW'(c2);
          state_d    = S_DN2;
        end else begin
          state_d = S_DNC;
        end
      end
      S_DN2: begin
        if (cmp_lt) begin
          ch_key_d = h_key;
          ch_val_d = h_val;
          cidx_d   = SW'(c2);
        end
        state_d = S_DNC;
      end
      S_DNC: begin
        if (cmp_lt) begin
          heap_we    = 1'b1;
          heap_wdata = {ch_key_q, ch_val_q};
          pos_we     = 1'b1;
          pos_waddr  = KA'(ch_key_q);
          idx_d      = cidx_q;
          state_d    = S_DN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.out_key     = rkey_q;
          out_d.out_value   = IN_VALUE_BITS'(rval_q);
          out_d.status      = stat_q;
          out_d.count_after = COUNT_BITS'(cnt_q);
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    key_q     <= key_d;
    val_q     <= val_d;
    idx_q     <= idx_d;
    cidx_q    <= cidx_d;
    cur_key_q <= cur_key_d;
    cur_val_q <= cur_val_d;
    ch_key_q  <= ch_key_d;
    ch_val_q  <= ch_val_d;
    rkey_q    <= rkey_d;
    rval_q    <= rval_d;
    stat_q    <= stat_d;
    out_q     <= out_d;
  end

endmodule

[rtl/imh_checker.sv]
// port-level assertions for the indexed min-heap, bound to the top level
`include "indexed_min_heap_decrement_top_defines.svh"

module imh_checker
  import imh_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  `IMH_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))
  `IMH_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `IMH_ASSERT_NOW(a_empty_pop_count, out_valid_o && out_item_o.status == ST_EMPTY, out_item_o.count_after == '0)
  `IMH_ASSERT_NOW(a_reject_no_payload, out_valid_o && out_item_o.status != ST_DONE, out_item_o.out_key == '0 && out_item_o.out_value == '0)

endmodule

bind indexed_min_heap_decrement_top imh_checker u_imh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

[tb/sv/tb_top.sv]
// testbench for the indexed min-heap with insert, decrement and pop-min
`timescale 1ns / 1ps

module tb_top
  import imh_pkg::*;
();

  localparam int HEAP_SLOTS = 1024;

  class heap_scoreboard;
    logic [9:0]  slot_key [HEAP_SLOTS];
    logic [15:0] slot_val [HEAP_SLOTS];
    int          key_slot [KEY_SPACE];
    bit          key_held [KEY_SPACE];
    int          held;
    out_item_t   pending [$];
    int          mismatches;
    int          compared;

    function void clear();
      held = 0;
      foreach (key_held[k]) key_held[k] = 0;
      pending.delete();
      mismatches = 0;
      compared = 0;
    endfunction

    function void swap_slots(int a, int b);
      logic [9:0]  ka;
      logic [15:0] va;
      ka = slot_key[a];
      va = slot_val[a];
      slot_key[a] = slot_key[b];
      slot_val[a] = slot_val[b];
      slot_key[b] = ka;
      slot_val[b] = va;
      key_slot[slot_key[a]] = a;
      key_slot[slot_key[b]] = b;
    endfunction

    function void climb(int i);
      int p;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (slot_val[p] > slot_val[i]) begin
          swap_slots(i, p);
          i = p;
        end else begin
          break;
        end
      end
    endfunction

    function void descend();
      int i;
      int c;
      i = 0;
      forever begin
        c = 2 * i + 1;
        if (c >= held) break;
        if (c + 1 < held && slot_val[c + 1] < slot_val[c]) c = c + 1;
        if (slot_val[c] < slot_val[i]) begin
          swap_slots(i, c);
          i = c;
        end else begin
          break;
        end
      end
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      int s;
      r = '0;
      r.status = ST_DONE;
      case (it.action)
        ACT_INSERT: begin
          if (held >= HEAP_SLOTS) begin
            r.status = ST_FULL;
          end else if (key_held[it.item_key]) begin
            r.status = ST_PRESENT;
          end else begin
            s = held;
            slot_key[s] = it.item_key;
            slot_val[s] = it.item_value;
            key_slot[it.item_key] = s;
            key_held[it.item_key] = 1;
            held++;
            climb(s);
          end
        end
        ACT_DEC: begin
          if (!key_held[it.item_key]) begin
            r.status = ST_ABSENT;
          end else begin
            s = key_slot[it.item_key];
            if (slot_val[s] != 0) slot_val[s] = slot_val[s] - 1;
            climb(s);
          end
        end
        ACT_POP: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.out_key = slot_key[0];
            r.out_value = slot_val[0];
            key_held[slot_key[0]] = 0;
            held--;
            if (held > 0) begin
              slot_key[0] = slot_key[held];
              slot_val[0] = slot_val[held];
              key_slot[slot_key[0]] = 0;
              descend();
            end
          end
        end
        default: ;
      endcase
      r.count_after = held[10:0];
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      compared++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got.out_key !== exp.out_key || got.out_value !== exp.out_value ||
          got.status !== exp.status || got.count_after !== exp.count_after) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp, got);
      end
    endfunction
  endclass

  logic      clk_i = 0;
  logic      rst_ni = 0;
  logic      in_valid_i = 0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 0;
  out_item_t out_item_o;

  heap_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 0;
  int sent = 0;
  int n_ins = 0, n_dec = 0, n_pop = 0, n_nop = 0, max_fill = 0;

  indexed_min_heap_decrement_top uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  // receiver side: random stall, forced stall during hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);
    out_stall_i <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_item(action_e act, logic [9:0] k, logic [15:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_item_i <= '{action: act, item_key: k, item_value: v};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(in_item_i);
    sent++;
    case (act)
      ACT_INSERT: n_ins++;
      ACT_DEC: n_dec++;
      ACT_POP: n_pop++;
      default: n_nop++;
    endcase
    if (sb.held > max_fill) max_fill = sb.held;
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed corners
    send_item(ACT_POP, 10'h3ff, 16'hffff);
    send_item(ACT_DEC, 10'd5, 16'd0);
    send_item(ACT_INSERT, 10'd0, 16'd0);
    send_item(ACT_INSERT, 10'h3ff, 16'hffff);
    send_item(ACT_INSERT, 10'd0, 16'd7);
    send_item(ACT_DEC, 10'd0, 16'hffff);
    send_item(ACT_INSERT, 10'h155, 16'h5555);
    send_item(ACT_INSERT, 10'h2aa, 16'haaaa);
    send_item(ACT_DEC, 10'h2aa, 16'd0);
    send_item(ACT_NOP, 10'h3ff, 16'hffff);
    send_item(ACT_POP, 10'd0, 16'd0);
    send_item(ACT_POP, 10'd0, 16'd0);
    send_item(ACT_POP, 10'd0, 16'd0);
    send_item(ACT_POP, 10'd0, 16'd0);
    send_item(ACT_POP, 10'd0, 16'd0);
    send_item(ACT_INSERT, 10'd9, 16'd1);
    send_item(ACT_DEC, 10'd9, 16'd0);
    send_item(ACT_DEC, 10'd9, 16'd0);
    send_item(ACT_POP, 10'd0, 16'd0);

    // fill to capacity across the idle phases
    send_idle_pct = 13;
    recv_idle_pct = 82;
    for (int k = 0; k < 340; k++) send_item(ACT_INSERT, 10'(k), 16'($urandom));

    // long receiver hold-off while inputs keep coming
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      for (int k = 340; k < 346; k++) send_item(ACT_INSERT, 10'(k), 16'($urandom));
    join

    send_idle_pct = 82;
    recv_idle_pct = 13;
    for (int k = 346; k < 686; k++) send_item(ACT_INSERT, 10'(k), 16'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int k = 686; k < HEAP_SLOTS; k++) send_item(ACT_INSERT, 10'(k), 16'($urandom));

    // full inserts, decrements and pops on the full heap
    send_item(ACT_INSERT, 10'd3, 16'd3);
    send_item(ACT_INSERT, 10'd3, 16'd3);
    repeat (4) send_item(ACT_DEC, 10'($urandom), 16'd0);
    repeat (4) send_item(ACT_POP, 10'd0, 16'd0);
    in_valid_i <= 0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("%0d transactions: %0d insert, %0d decrement, %0d pop, %0d no-op",
             sent, n_ins, n_dec, n_pop, n_nop);
    $display("%0d results compared, peak fill %0d, %0d mismatches",
             sb.compared, max_fill, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/imh_pkg.sv
rtl/imh_ram.sv
rtl/indexed_min_heap_decrement_top.sv
rtl/imh_checker.sv
tb/sv/tb_top.sv
